@@ src/shnr_pkg.sv @@
// shnr_pkg: constants, types, weight and keyword tables for the header name recognizer.
// No dependencies.
`timescale 1ns / 1ps
package shnr_pkg;

    localparam int MAX_NAME_LEN = 19;
    localparam int MIN_NAME_LEN = 2;
    localparam int TOP_KEY      = 157;
    localparam int NO_WEIGHT    = 158;

    typedef logic [7:0]  byte_t;
    typedef logic [4:0]  count_t;
    typedef logic [11:0] sum_t;
    typedef logic [5:0]  code_t;
    typedef logic [7:0]  slot_t;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_COMPARE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic take;
        logic start_cmp;
        logic step_cmp;
        logic done_cmp;
    } cmd_t;

    typedef struct packed {
        logic cmp_done;
    } status_t;

    function automatic byte_t to_lower(input byte_t c);
        byte_t r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [7:0] letter_weight(input logic [4:0] i);
        logic [7:0] w;
        case (i)
            5'd1:  w = 8'd25;
            5'd3:  w = 8'd5;
            5'd5:  w = 8'd50;
            5'd7:  w = 8'd5;
            5'd9:  w = 8'd15;
            5'd10: w = 8'd158;
            5'd11: w = 8'd30;
            5'd12: w = 8'd35;
            5'd16: w = 8'd35;
            5'd21: w = 8'd25;
            5'd22: w = 8'd30;
            5'd23: w = 8'd25;
            5'd24: w = 8'd15;
            default: w = 8'd0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] byte_weight(input byte_t c);
        byte_t l;
        logic [7:0] w;
        l = to_lower(c);
        if (l >= 8'h61 && l <= 8'h7A)
        begin
            w = letter_weight(5'(l - 8'h61));
        end
        else if (l == 8'h2D)
        begin
            w = 8'd0;
        end
        else
        begin
            w = 8'(NO_WEIGHT);
        end
        return w;
    endfunction

    typedef struct packed {
        logic         valid;
        code_t        code;
        logic [151:0] text;
    } kw_entry_t;

    function automatic logic [151:0] pack_str(input string s);
        logic [151:0] r;
        r = '0;
        for (int i = 0; i < MAX_NAME_LEN; i++)
        begin
            if (i < s.len())
            begin
                r[i*8 +: 8] = s[i];
            end
        end
        return r;
    endfunction

    function automatic kw_entry_t kw(input int code, input string s);
        kw_entry_t e;
        e.valid = 1'b1;
        e.code  = 6'(code);
        e.text  = pack_str(s);
        return e;
    endfunction

    function automatic kw_entry_t keyword_at(input slot_t slot);
        kw_entry_t e;
        e = '0;
        case (slot)
            8'd2:   e = kw(0, "to");
            8'd5:   e = kw(1, "route");
            8'd6:   e = kw(2, "accept");
            8'd7:   e = kw(3, "contact");
            8'd9:   e = kw(4, "date");
            8'd10:  e = kw(5, "user-agent");
            8'd12:  e = kw(6, "organization");
            8'd14:  e = kw(7, "supported");
            8'd16:  e = kw(8, "unsupported");
            8'd17:  e = kw(9, "record-route");
            8'd18:  e = kw(10, "authorization");
            8'd20:  e = kw(11, "accept-encoding");
            8'd21:  e = kw(12, "content-encoding");
            8'd23:  e = kw(13, "priority");
            8'd24:  e = kw(14, "content-disposition");
            8'd27:  e = kw(15, "content-type");
            8'd28:  e = kw(16, "via");
            8'd31:  e = kw(17, "server");
            8'd32:  e = kw(18, "expires");
            8'd37:  e = kw(19, "warning");
            8'd38:  e = kw(20, "replaces");
            8'd39:  e = kw(21, "cseq");
            8'd42:  e = kw(22, "require");
            8'd43:  e = kw(23, "subscription-state");
            8'd45:  e = kw(24, "accept-language");
            8'd46:  e = kw(25, "content-language");
            8'd47:  e = kw(26, "subject");
            8'd49:  e = kw(27, "content-length");
            8'd53:  e = kw(28, "reply-to");
            8'd56:  e = kw(29, "in-reply-to");
            8'd58:  e = kw(30, "refer-to");
            8'd60:  e = kw(31, "error-info");
            8'd63:  e = kw(32, "proxy-authenticate");
            8'd64:  e = kw(33, "proxy-authorization");
            8'd71:  e = kw(34, "min-expires");
            8'd72:  e = kw(35, "call-id");
            8'd74:  e = kw(36, "authentication-info");
            8'd76:  e = kw(37, "retry-after");
            8'd79:  e = kw(38, "timestamp");
            8'd88:  e = kw(39, "proxy-require");
            8'd89:  e = kw(40, "from");
            8'd90:  e = kw(41, "alert-info");
            8'd95:  e = kw(42, "allow");
            8'd106: e = kw(43, "referred-by");
            8'd107: e = kw(44, "mime-version");
            8'd111: e = kw(45, "www-authenticate");
            8'd119: e = kw(46, "call-info");
            8'd157: e = kw(47, "max-forwards");
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

@@ src/shnr_if.sv @@
// shnr_in_if / shnr_out_if: valid/ready channels for name bytes and results.
// Depends on shnr_pkg.
`timescale 1ns / 1ps
interface shnr_in_if;
    logic              valid;
    logic              ready;
    shnr_pkg::byte_t   name_byte;
    logic              last_byte;
    modport source (output valid, output name_byte, output last_byte, input ready);
    modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

interface shnr_out_if;
    logic              valid;
    logic              ready;
    logic              recognized;
    shnr_pkg::code_t   header_code;
    modport source (output valid, output recognized, output header_code, input ready);
    modport sink   (input valid, input recognized, input header_code, output ready);
endinterface

@@ src/shnr_ctrl.sv @@
// shnr_ctrl: controller FSM sequencing collect, byte compare and result hand-off.
// Depends on shnr_pkg.
`timescale 1ns / 1ps
module shnr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  shnr_pkg::status_t status,
    output shnr_pkg::cmd_t    cmd
);
    import shnr_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (in_last)
                    begin
                        cmd.start_cmp = 1'b1;
                        state_next    = ST_COMPARE;
                    end
                end
            end
            ST_COMPARE:
            begin
                cmd.step_cmp = 1'b1;
                if (status.cmp_done)
                begin
                    cmd.done_cmp = 1'b1;
                    state_next   = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    a_out_after_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPARE && status.cmp_done) |=> out_valid)
        else $error("result not presented after compare");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_COLLECT) |-> !cmd.take)
        else $error("byte taken while busy");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");
endmodule

@@ src/shnr_datapath.sv @@
// shnr_datapath: byte store, count, weight sum, key lookup and serial byte compare.
// Depends on shnr_pkg.
`timescale 1ns / 1ps
module shnr_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  shnr_pkg::cmd_t    cmd,
    input  shnr_pkg::byte_t   name_byte,
    output shnr_pkg::status_t status,
    output logic              recognized,
    output shnr_pkg::code_t   header_code
);
    import shnr_pkg::*;

    byte_t       store_reg [MAX_NAME_LEN];
    count_t      count_reg, count_next;
    sum_t        sum_reg, sum_next;
    count_t      len_reg;
    count_t      idx_reg;
    logic        ok_reg;
    kw_entry_t   entry_reg;
    logic        rec_reg;
    code_t       code_reg;
    byte_t       rd_reg;
    logic        rd_valid_reg;

    logic [12:0] key;
    logic        key_ok;
    byte_t       kch;
    logic        mismatch;

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (count_reg < count_t'(MAX_NAME_LEN))
        begin
            count_next = count_reg + 5'd1;
            sum_next   = sum_reg + sum_t'(byte_weight(name_byte));
        end
        else
        begin
            count_next = count_t'(MAX_NAME_LEN + 1);
        end
        key    = 13'(count_next) + 13'(sum_next);
        key_ok = count_next >= count_t'(MIN_NAME_LEN) && count_next <= count_t'(MAX_NAME_LEN)
                 && key <= 13'(TOP_KEY);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && count_reg < count_t'(MAX_NAME_LEN))
        begin
            store_reg[count_reg] <= name_byte;
        end
        if (cmd.start_cmp)
        begin
            entry_reg <= keyword_at(key_ok ? key[7:0] : 8'd0);
            len_reg   <= count_next;
        end
        rd_reg <= to_lower(store_reg[idx_reg]);
    end

    // keyword byte that pairs with rd_reg
    assign kch      = entry_reg.text[(idx_reg - 5'd1)*8 +: 8];
    assign mismatch = rd_valid_reg && rd_reg != kch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= '0;
            idx_reg      <= '0;
            ok_reg       <= 1'b0;
            rd_valid_reg <= 1'b0;
            rec_reg      <= 1'b0;
            code_reg     <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                count_reg <= cmd.start_cmp ? '0 : count_next;
                sum_reg   <= cmd.start_cmp ? '0 : sum_next;
            end
            if (cmd.start_cmp)
            begin
                idx_reg      <= '0;
                ok_reg       <= key_ok;
                rd_valid_reg <= 1'b0;
            end
            else if (cmd.step_cmp && !status.cmp_done)
            begin
                rd_valid_reg <= 1'b1;
                if (idx_reg < len_reg)
                begin
                    idx_reg <= idx_reg + 5'd1;
                end
            end
            if (cmd.done_cmp)
            begin
                rec_reg  <= ok_reg && entry_reg.valid && !mismatch;
                code_reg <= (ok_reg && entry_reg.valid && !mismatch) ? entry_reg.code : '0;
            end
        end
    end

    // done on a bad key, an empty keyword slot, a mismatch, or once every stored byte has been compared
    assign status.cmp_done = !ok_reg || !entry_reg.valid || mismatch ||
                             (idx_reg == len_reg && rd_valid_reg);
    assign recognized  = rec_reg;
    assign header_code = code_reg;

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= count_t'(MAX_NAME_LEN))
        else $error("compare index out of range");
    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !rec_reg |-> code_reg == '0)
        else $error("code without match");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(MAX_NAME_LEN + 1))
        else $error("count overflow");
endmodule

@@ src/sip_header_name_recognizer_core.sv @@
// sip_header_name_recognizer_core: top level joining controller and datapath.
// Depends on shnr_pkg, shnr_if, shnr_ctrl, shnr_datapath.
//
//  channel  dir  payload
//  in_ch    in   name_byte[7:0], last_byte
//  out_ch   out  recognized, header_code[5:0]
//
// Bytes are taken one per cycle while collecting. A final byte starts a serial
// compare, one stored byte per cycle; a mismatch or unknown key ends it early.
// The result holds until taken, no byte is accepted meanwhile, and bytes are
// accepted again in the cycle after the result is taken. Reset clears count,
// sum and control; the byte store needs no clearing.
`timescale 1ns / 1ps
module sip_header_name_recognizer_core (
    input  logic clk,
    input  logic rst_n,
    shnr_in_if.sink    in_ch,
    shnr_out_if.source out_ch
);
    import shnr_pkg::*;

    cmd_t    cmd;
    status_t status;

    shnr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last_byte),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    shnr_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .name_byte   (in_ch.name_byte),
        .status      (status),
        .recognized  (out_ch.recognized),
        .header_code (out_ch.header_code)
    );
endmodule
